/* rtl/core/ilff_pkg.sv */
// Shared types and constants of the first-fit heap allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package ilff_pkg;

    localparam int TAG_W = 18;
    localparam int MIN_SPLIT = 16;

    localparam logic [TAG_W-1:0] PROLOGUE_TAG = 18'd9;
    localparam logic [TAG_W-1:0] EPILOGUE_TAG = 18'd1;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_ZERO = 2'd2;

    typedef enum logic [4:0] {
        UOP_NOP,
        UOP_INIT1,
        UOP_INIT2,
        UOP_INIT3,
        UOP_ALLOC_START,
        UOP_FREE_START,
        UOP_WALK_RD,
        UOP_WALK_NEXT,
        UOP_TAKE,
        UOP_GROW_H,
        UOP_GROW_F,
        UOP_GROW_E,
        UOP_M_RD0,
        UOP_M_RD1,
        UOP_M_RD2,
        UOP_M_DEC,
        UOP_MW_H,
        UOP_MW_F,
        UOP_PL_S1,
        UOP_PL_S2,
        UOP_PL_H,
        UOP_PL_F,
        UOP_FR_H,
        UOP_FR_F
    } uop_t;

    typedef enum logic [2:0] {
        FIN_NONE,
        FIN_OK,
        FIN_FULL,
        FIN_ZERO,
        FIN_FREE
    } fin_t;

    typedef struct packed {
        uop_t uop;
        fin_t fin;
    } cmd_t;

    typedef struct packed {
        logic in_free;
        logic zero_req;
        logic in_heap;
        logic size_zero;
        logic fits;
        logic hit;
        logic past;
        logic alloc_bit;
        logic no_room;
        logic split;
        logic both_alloc;
        logic op_free;
    } flags_t;

    // Builds a boundary tag from a size (multiple of 8) and the allocated flag.
    function automatic logic [TAG_W-1:0] make_tag(input logic [TAG_W-1:0] size,
                                                  input logic alloc);
        return {size[TAG_W-1:3], 2'b00, alloc};
    endfunction

endpackage

/* rtl/core/ilff_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module ilff_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/ilff_ctrl.sv */
// Sequencer of the allocator: walks, grows, merges and places blocks.
// Uses ilff_pkg for the command and flag types.
`timescale 1ns / 1ps

module ilff_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  ilff_pkg::flags_t flags,
    output ilff_pkg::cmd_t  cmd,
    output logic            busy
);

    typedef enum logic [24:0] {
        S_INIT1 = 25'h0000001,
        S_INIT2 = 25'h0000002,
        S_INIT3 = 25'h0000004,
        S_IDLE  = 25'h0000008,
        S_WRD   = 25'h0000010,
        S_WCHK  = 25'h0000020,
        S_GCK   = 25'h0000040,
        S_GH    = 25'h0000080,
        S_GF    = 25'h0000100,
        S_GE    = 25'h0000200,
        S_M0    = 25'h0000400,
        S_M1    = 25'h0000800,
        S_M2    = 25'h0001000,
        S_M3    = 25'h0002000,
        S_MH    = 25'h0004000,
        S_MF    = 25'h0008000,
        S_P0    = 25'h0010000,
        S_PS1   = 25'h0020000,
        S_PS2   = 25'h0040000,
        S_PH    = 25'h0080000,
        S_PF    = 25'h0100000,
        S_FRD   = 25'h0200000,
        S_FCHK  = 25'h0400000,
        S_FH    = 25'h0800000,
        S_FF    = 25'h1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.uop    = ilff_pkg::UOP_NOP;
        cmd.fin    = ilff_pkg::FIN_NONE;
        unique case (state_reg)
            S_INIT1:
            begin
                cmd.uop    = ilff_pkg::UOP_INIT1;
                state_next = S_INIT2;
            end
            S_INIT2:
            begin
                cmd.uop    = ilff_pkg::UOP_INIT2;
                state_next = S_INIT3;
            end
            S_INIT3:
            begin
                cmd.uop    = ilff_pkg::UOP_INIT3;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (flags.in_free)
                    begin
                        cmd.uop    = ilff_pkg::UOP_FREE_START;
                        state_next = S_FRD;
                    end
                    else if (flags.zero_req)
                    begin
                        cmd.fin = ilff_pkg::FIN_ZERO;
                    end
                    else
                    begin
                        cmd.uop    = ilff_pkg::UOP_ALLOC_START;
                        state_next = S_WRD;
                    end
                end
            end
            S_WRD:
            begin
                cmd.uop    = ilff_pkg::UOP_WALK_RD;
                state_next = flags.in_heap ? S_WCHK : S_GCK;
            end
            S_WCHK:
            begin
                if (flags.size_zero)
                begin
                    state_next = S_GCK;
                end
                else if (flags.fits)
                begin
                    cmd.uop    = ilff_pkg::UOP_TAKE;
                    state_next = S_P0;
                end
                else
                begin
                    cmd.uop    = ilff_pkg::UOP_WALK_NEXT;
                    state_next = S_WRD;
                end
            end
            S_GCK:
            begin
                if (flags.no_room)
                begin
                    cmd.fin    = ilff_pkg::FIN_FULL;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_GH;
                end
            end
            S_GH:
            begin
                cmd.uop    = ilff_pkg::UOP_GROW_H;
                state_next = S_GF;
            end
            S_GF:
            begin
                cmd.uop    = ilff_pkg::UOP_GROW_F;
                state_next = S_GE;
            end
            S_GE:
            begin
                cmd.uop    = ilff_pkg::UOP_GROW_E;
                state_next = S_M0;
            end
            S_M0:
            begin
                cmd.uop    = ilff_pkg::UOP_M_RD0;
                state_next = S_M1;
            end
            S_M1:
            begin
                cmd.uop    = ilff_pkg::UOP_M_RD1;
                state_next = S_M2;
            end
            S_M2:
            begin
                cmd.uop    = ilff_pkg::UOP_M_RD2;
                state_next = S_M3;
            end
            S_M3:
            begin
                if (flags.both_alloc)
                begin
                    if (flags.op_free)
                    begin
                        cmd.fin    = ilff_pkg::FIN_FREE;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_P0;
                    end
                end
                else
                begin
                    cmd.uop    = ilff_pkg::UOP_M_DEC;
                    state_next = S_MH;
                end
            end
            S_MH:
            begin
                cmd.uop    = ilff_pkg::UOP_MW_H;
                state_next = S_MF;
            end
            S_MF:
            begin
                cmd.uop = ilff_pkg::UOP_MW_F;
                if (flags.op_free)
                begin
                    cmd.fin    = ilff_pkg::FIN_FREE;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_P0;
                end
            end
            S_P0:
            begin
                state_next = flags.split ? S_PS1 : S_PH;
            end
            S_PS1:
            begin
                cmd.uop    = ilff_pkg::UOP_PL_S1;
                state_next = S_PS2;
            end
            S_PS2:
            begin
                cmd.uop    = ilff_pkg::UOP_PL_S2;
                state_next = S_PH;
            end
            S_PH:
            begin
                cmd.uop    = ilff_pkg::UOP_PL_H;
                state_next = S_PF;
            end
            S_PF:
            begin
                cmd.uop    = ilff_pkg::UOP_PL_F;
                cmd.fin    = ilff_pkg::FIN_OK;
                state_next = S_IDLE;
            end
            S_FRD:
            begin
                cmd.uop = ilff_pkg::UOP_WALK_RD;
                if (flags.in_heap)
                begin
                    state_next = S_FCHK;
                end
                else
                begin
                    cmd.fin    = ilff_pkg::FIN_FREE;
                    state_next = S_IDLE;
                end
            end
            S_FCHK:
            begin
                if (flags.size_zero || flags.past || (flags.hit && !flags.alloc_bit))
                begin
                    cmd.fin    = ilff_pkg::FIN_FREE;
                    state_next = S_IDLE;
                end
                else if (flags.hit)
                begin
                    cmd.uop    = ilff_pkg::UOP_TAKE;
                    state_next = S_FH;
                end
                else
                begin
                    cmd.uop    = ilff_pkg::UOP_WALK_NEXT;
                    state_next = S_FRD;
                end
            end
            S_FH:
            begin
                cmd.uop    = ilff_pkg::UOP_FR_H;
                state_next = S_FF;
            end
            S_FF:
            begin
                cmd.uop    = ilff_pkg::UOP_FR_F;
                state_next = S_M0;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/ilff_dp.sv */
// Datapath of the allocator: tag store, block pointers, sizes and results.
// Uses ilff_pkg and instantiates ilff_ram.
`timescale 1ns / 1ps

module ilff_dp #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ilff_pkg::cmd_t   cmd,
    input  logic             kind,
    input  logic [15:0]      request_bytes,
    input  logic [15:0]      block_address,
    output ilff_pkg::flags_t flags,
    output logic             done,
    output logic [15:0]      payload_address,
    output logic [1:0]       status
);

    localparam int DEPTH = HEAP_BYTES / 4;
    localparam int IW    = $clog2(DEPTH);
    localparam int AW0   = $clog2(HEAP_BYTES) + 2;
    localparam int AW    = (AW0 > 19) ? AW0 : 19;
    localparam int TW    = ilff_pkg::TAG_W;

    logic [AW-1:0] bp_reg, cur_reg, asize_reg, prev_reg, psize_reg, heap_top_reg;
    logic          pa_reg, op_free_reg, done_reg;
    logic [15:0]   tgt_reg, addr_out_reg;
    logic [1:0]    status_reg;

    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [TW-1:0] wdata, rdata;

    logic [AW-1:0] size_rd, grow, room, req_size, rem, new_bp, total, tgt_ext;

    // Keeps only the bits of a size that a tag word can hold.
    function automatic logic [AW-1:0] trim(input logic [AW-1:0] x);
        return {{(AW-TW){1'b0}}, x[TW-1:0]};
    endfunction

    assign size_rd  = {{(AW-TW){1'b0}}, rdata[TW-1:3], 3'b000};
    assign grow     = asize_reg + AW'(8);
    assign room     = AW'(HEAP_BYTES) - heap_top_reg;
    assign req_size = (AW'(request_bytes) + AW'(15)) & ~AW'(7);
    assign rem      = cur_reg - asize_reg;
    assign tgt_ext  = AW'(tgt_reg);

    // Merge decision: rdata holds the next block's header here.
    always_comb
    begin
        new_bp = bp_reg;
        total  = cur_reg;
        if (!pa_reg && !rdata[0])
        begin
            new_bp = prev_reg;
            total  = psize_reg + cur_reg + size_rd;
        end
        else if (!pa_reg)
        begin
            new_bp = prev_reg;
            total  = psize_reg + cur_reg;
        end
        else if (!rdata[0])
        begin
            total = cur_reg + size_rd;
        end
    end

    always_comb
    begin
        flags.in_free    = kind;
        flags.zero_req   = (request_bytes == 16'd0);
        flags.in_heap    = ((bp_reg - AW'(4)) < heap_top_reg);
        flags.size_zero  = (rdata[TW-1:3] == '0);
        flags.fits       = (size_rd >= asize_reg) && !rdata[0];
        flags.hit        = (bp_reg == tgt_ext);
        flags.past       = (bp_reg > tgt_ext);
        flags.alloc_bit  = rdata[0];
        flags.no_room    = (grow > room);
        flags.split      = (cur_reg >= asize_reg) && (rem >= AW'(ilff_pkg::MIN_SPLIT));
        flags.both_alloc = pa_reg && rdata[0];
        flags.op_free    = op_free_reg;
    end

    always_comb
    begin
        we    = 1'b0;
        re    = 1'b0;
        waddr = '0;
        raddr = '0;
        wdata = '0;
        unique case (cmd.uop) inside
            ilff_pkg::UOP_INIT1:
            begin
                we    = 1'b1;
                waddr = AW'(4);
                wdata = ilff_pkg::PROLOGUE_TAG;
            end
            ilff_pkg::UOP_INIT2:
            begin
                we    = 1'b1;
                waddr = AW'(8);
                wdata = ilff_pkg::PROLOGUE_TAG;
            end
            ilff_pkg::UOP_INIT3:
            begin
                we    = 1'b1;
                waddr = AW'(12);
                wdata = ilff_pkg::EPILOGUE_TAG;
            end
            ilff_pkg::UOP_WALK_RD:
            begin
                re    = 1'b1;
                raddr = bp_reg - AW'(4);
            end
            ilff_pkg::UOP_GROW_H:
            begin
                we    = 1'b1;
                waddr = heap_top_reg - AW'(4);
                wdata = ilff_pkg::make_tag(grow[TW-1:0], 1'b0);
            end
            ilff_pkg::UOP_GROW_F, ilff_pkg::UOP_MW_F, ilff_pkg::UOP_FR_F:
            begin
                we    = 1'b1;
                waddr = bp_reg + cur_reg - AW'(8);
                wdata = ilff_pkg::make_tag(cur_reg[TW-1:0], 1'b0);
            end
            ilff_pkg::UOP_GROW_E:
            begin
                we    = 1'b1;
                waddr = bp_reg + cur_reg - AW'(4);
                wdata = ilff_pkg::EPILOGUE_TAG;
            end
            ilff_pkg::UOP_M_RD0:
            begin
                re    = 1'b1;
                raddr = bp_reg - AW'(8);
            end
            ilff_pkg::UOP_M_RD1:
            begin
                re    = 1'b1;
                raddr = bp_reg - size_rd - AW'(4);
            end
            ilff_pkg::UOP_M_RD2:
            begin
                re    = 1'b1;
                raddr = bp_reg + cur_reg - AW'(4);
            end
            ilff_pkg::UOP_MW_H, ilff_pkg::UOP_FR_H:
            begin
                we    = 1'b1;
                waddr = bp_reg - AW'(4);
                wdata = ilff_pkg::make_tag(cur_reg[TW-1:0], 1'b0);
            end
            ilff_pkg::UOP_PL_S1:
            begin
                we    = 1'b1;
                waddr = bp_reg + asize_reg - AW'(4);
                wdata = ilff_pkg::make_tag(rem[TW-1:0], 1'b0);
            end
            ilff_pkg::UOP_PL_S2:
            begin
                we    = 1'b1;
                waddr = bp_reg + cur_reg - AW'(8);
                wdata = ilff_pkg::make_tag(rem[TW-1:0], 1'b0);
            end
            ilff_pkg::UOP_PL_H:
            begin
                we    = 1'b1;
                waddr = bp_reg - AW'(4);
                wdata = ilff_pkg::make_tag(cur_reg[TW-1:0], 1'b1);
            end
            ilff_pkg::UOP_PL_F:
            begin
                we    = 1'b1;
                waddr = bp_reg + cur_reg - AW'(8);
                wdata = ilff_pkg::make_tag(cur_reg[TW-1:0], 1'b1);
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    ilff_ram #(
        .WIDTH(TW),
        .DEPTH(DEPTH)
    ) u_tags (
        .clk  (clk),
        .we   (we),
        .waddr(waddr[IW+1:2]),
        .wdata(wdata),
        .re   (re),
        .raddr(raddr[IW+1:2]),
        .rdata(rdata)
    );

    // Control state: top of heap and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_top_reg <= AW'(16);
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.fin != ilff_pkg::FIN_NONE);
            if (cmd.uop == ilff_pkg::UOP_GROW_E)
            begin
                heap_top_reg <= heap_top_reg + cur_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.uop) inside
            ilff_pkg::UOP_ALLOC_START:
            begin
                asize_reg   <= req_size;
                bp_reg      <= AW'(8);
                op_free_reg <= 1'b0;
            end
            ilff_pkg::UOP_FREE_START:
            begin
                bp_reg      <= AW'(8);
                tgt_reg     <= block_address;
                op_free_reg <= 1'b1;
            end
            ilff_pkg::UOP_WALK_NEXT: bp_reg <= bp_reg + size_rd;
            ilff_pkg::UOP_TAKE:      cur_reg <= size_rd;
            ilff_pkg::UOP_GROW_H:
            begin
                bp_reg  <= heap_top_reg;
                cur_reg <= grow;
            end
            ilff_pkg::UOP_GROW_E, ilff_pkg::UOP_MW_F: cur_reg <= trim(cur_reg);
            ilff_pkg::UOP_M_RD1:     prev_reg <= bp_reg - size_rd;
            ilff_pkg::UOP_M_RD2:
            begin
                psize_reg <= size_rd;
                pa_reg    <= rdata[0];
            end
            ilff_pkg::UOP_M_DEC:
            begin
                bp_reg  <= new_bp;
                cur_reg <= total;
            end
            ilff_pkg::UOP_PL_S2:     cur_reg <= asize_reg;
            default:
            begin
            end
        endcase

        case (cmd.fin)
            ilff_pkg::FIN_OK:
            begin
                addr_out_reg <= bp_reg[15:0];
                status_reg   <= ilff_pkg::STATUS_OK;
            end
            ilff_pkg::FIN_FULL:
            begin
                addr_out_reg <= 16'd0;
                status_reg   <= ilff_pkg::STATUS_FULL;
            end
            ilff_pkg::FIN_ZERO:
            begin
                addr_out_reg <= 16'd0;
                status_reg   <= ilff_pkg::STATUS_ZERO;
            end
            ilff_pkg::FIN_FREE:
            begin
                addr_out_reg <= 16'd0;
                status_reg   <= ilff_pkg::STATUS_OK;
            end
            default:
            begin
            end
        endcase
    end

    assign done            = done_reg;
    assign payload_address = addr_out_reg;
    assign status          = status_reg;

endmodule

/* rtl/core/implicit_list_first_fit_allocator.sv */
// Top level of the first-fit heap allocator with boundary tags.
// Uses ilff_pkg; instantiates ilff_ctrl and ilff_dp (which holds ilff_ram).
`timescale 1ns / 1ps

// How to use this block:
// A request is taken at a rising edge where start is high and busy is low.
// kind selects allocate (0, size in request_bytes) or free (1, payload
// offset in block_address). Each request produces exactly one result item:
// done is high for one cycle with payload_address and status valid. The
// receiver cannot stall, so it must take the item in that cycle.
// A zero-size request is answered in the cycle after it is taken. An
// allocate makes one tag read and one check for every block the first-fit
// walk visits, the epilogue included when nothing fits. It then places
// the block in the free block found, or first grows the heap and merges
// the new block with free neighbours. A free walks the list the same way
// up to its block and then clears and merges it. One request is in
// progress at a time; busy stays high until the cycle the result is being
// registered, so the next request can be taken in the cycle that done is
// shown.
// After reset the block writes the two prologue tags and the epilogue tag
// with busy high; the heap top starts at 16 bytes and the rest of the tag
// store is not cleared.

module implicit_list_first_fit_allocator #(
    parameter int HEAP_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        kind,
    input  logic [15:0] request_bytes,
    input  logic [15:0] block_address,
    output logic        done,
    output logic [15:0] payload_address,
    output logic [1:0]  status
);

    ilff_pkg::cmd_t   cmd;
    ilff_pkg::flags_t flags;

    // The sequencer only decides; all storage and arithmetic is in the datapath.
    ilff_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .flags(flags),
        .cmd  (cmd),
        .busy (busy)
    );

    ilff_dp #(
        .HEAP_BYTES(HEAP_BYTES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .kind           (kind),
        .request_bytes  (request_bytes),
        .block_address  (block_address),
        .flags          (flags),
        .done           (done),
        .payload_address(payload_address),
        .status         (status)
    );

    // A result is only shown once the sequencer is back to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while a request is still in progress");

    // A zero-size allocate answers in the next cycle with its own status.
    a_zero_req: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !kind && request_bytes == 16'd0)
            |=> (done && status == ilff_pkg::STATUS_ZERO))
        else $error("zero-size request not answered next cycle");

    // Errors never carry an address.
    a_err_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ilff_pkg::STATUS_OK) |-> (payload_address == 16'd0))
        else $error("error result carries a payload address");

    // Only the three defined status codes ever appear.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ilff_pkg::STATUS_OK || status == ilff_pkg::STATUS_FULL
                  || status == ilff_pkg::STATUS_ZERO))
        else $error("undefined status code");

endmodule

/* test/tb_top.sv */
// Self-checking testbench of the first-fit heap allocator with boundary tags.
// Depends on ilff_pkg and implicit_list_first_fit_allocator; holds its own heap predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int HEAP = 65536;
    localparam int TAG_WORDS = HEAP / 4;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE = 1'b1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        kind = KIND_ALLOC;
    logic [15:0] request_bytes = '0;
    logic [15:0] block_address = '0;
    logic        done;
    logic [15:0] payload_address;
    logic [1:0]  status;

    implicit_list_first_fit_allocator #(.HEAP_BYTES(HEAP)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .request_bytes(request_bytes), .block_address(block_address),
        .done(done), .payload_address(payload_address), .status(status)
    );

    always #10 clk = ~clk;

    typedef struct {
        logic [15:0] addr;
        logic [1:0]  stat;
    } answer_t;

    typedef struct {
        logic        k;
        logic [15:0] req;
        logic [15:0] addr;
        bit          typed;
        logic [15:0] exp_addr;
        logic [1:0]  exp_stat;
    } row_t;

    // Predictor state: one tag word per four heap bytes and the heap end.
    logic [17:0] heap_tag [TAG_WORDS];
    int unsigned heap_end;

    answer_t     pending_answers[$];
    logic [15:0] live_blocks[$];
    int          mismatches = 0;
    int          n_alloc = 0, n_free = 0, n_full = 0, n_zero = 0;
    bit          idle_on = 1'b1;
    bit          use_typed = 1'b0;
    answer_t     typed_answer;

    function automatic int unsigned tag_rd(int unsigned a);
        return (a >> 2) < TAG_WORDS ? heap_tag[a >> 2] : 0;
    endfunction

    function automatic void tag_wr(int unsigned a, int unsigned v);
        if ((a >> 2) < TAG_WORDS)
            heap_tag[a >> 2] = v[17:0];
    endfunction

    function automatic int unsigned bsize(int unsigned bp);
        return tag_rd(bp - 4) & 32'hFFFF_FFF8;
    endfunction

    function automatic int unsigned bused(int unsigned bp);
        return tag_rd(bp - 4) & 1;
    endfunction

    function automatic void mark(int unsigned bp, int unsigned sz, int unsigned used);
        tag_wr(bp - 4, sz | used);
        tag_wr(bp + sz - 8, sz | used);
    endfunction

    // Merges a free block with free neighbours and returns the merged block.
    function automatic int unsigned coalesce(int unsigned bp);
        int unsigned sz, prv, nxt;
        sz = bsize(bp);
        prv = bp - (tag_rd(bp - 8) & 32'hFFFF_FFF8);
        nxt = bp + sz;
        if (bused(prv) && bused(nxt))
            return bp;
        if (!bused(prv) && !bused(nxt))
        begin
            mark(prv, bsize(prv) + sz + bsize(nxt), 0);
            return prv;
        end
        if (!bused(prv))
        begin
            mark(prv, bsize(prv) + sz, 0);
            return prv;
        end
        mark(bp, sz + bsize(nxt), 0);
        return bp;
    endfunction

    function automatic void carve(int unsigned bp, int unsigned asize);
        int unsigned cur;
        cur = bsize(bp);
        if (cur >= asize && cur - asize >= ilff_pkg::MIN_SPLIT)
        begin
            mark(bp, asize, 0);
            mark(bp + asize, cur - asize, 0);
        end
        mark(bp, bsize(bp), 1);
    endfunction

    // Works out the answer of one request and updates the heap image.
    function automatic answer_t predict_heap(logic k, logic [15:0] req, logic [15:0] target);
        answer_t     ans;
        int unsigned asize, grow, bp;
        ans.addr = '0;
        ans.stat = ilff_pkg::STATUS_OK;
        if (k == KIND_ALLOC)
        begin
            if (req == 0)
            begin
                ans.stat = ilff_pkg::STATUS_ZERO;
                return ans;
            end
            asize = (req + 15) & 32'hFFFF_FFF8;
            bp = 8;
            while (bp - 4 < heap_end && bsize(bp) > 0)
            begin
                if (bsize(bp) >= asize && bused(bp) == 0)
                begin
                    carve(bp, asize);
                    ans.addr = bp[15:0];
                    return ans;
                end
                bp += bsize(bp);
            end
            grow = asize + 8;
            if (grow > HEAP - heap_end)
            begin
                ans.stat = ilff_pkg::STATUS_FULL;
                return ans;
            end
            bp = heap_end;
            mark(bp, grow, 0);
            tag_wr(bp + grow - 4, 1);
            heap_end += grow;
            bp = coalesce(bp);
            carve(bp, asize);
            ans.addr = bp[15:0];
        end
        else
        begin
            bp = 8;
            while (bp - 4 < heap_end && bsize(bp) > 0)
            begin
                if (bp == target)
                begin
                    if (bused(bp))
                    begin
                        mark(bp, bsize(bp), 0);
                        void'(coalesce(bp));
                    end
                    break;
                end
                if (bp > target)
                    break;
                bp += bsize(bp);
            end
        end
        return ans;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Monitor: checks the result shown in this cycle, then books the item taken
    // at this edge. Both use values from before the edge.
    always @(posedge clk)
    begin
        answer_t ans, want;
        int      i;
        if (done)
        begin
            if (pending_answers.size() == 0)
            begin
                report_mismatch("unexpected result, status", status, 0);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (payload_address !== want.addr)
                    report_mismatch("payload_address", payload_address, want.addr);
                if (status !== want.stat)
                    report_mismatch("status", status, want.stat);
            end
        end
        if (rst_n && start && !busy)
        begin
            ans = predict_heap(kind, request_bytes, block_address);
            if (kind == KIND_FREE)
            begin
                n_free++;
                for (i = 0; i < live_blocks.size(); i++)
                    if (live_blocks[i] == block_address)
                    begin
                        live_blocks.delete(i);
                        break;
                    end
            end
            else if (ans.stat == ilff_pkg::STATUS_OK)
            begin
                n_alloc++;
                live_blocks.push_back(ans.addr);
            end
            else if (ans.stat == ilff_pkg::STATUS_FULL)
            begin
                n_full++;
            end
            else
            begin
                n_zero++;
            end
            pending_answers.push_back(use_typed ? typed_answer : ans);
        end
    end

    // Watchdog: counts cycles in which neither an item nor a result moves.
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", pending_answers.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Drives one item from a falling edge and returns at the falling edge after
    // it was taken. Busy seen at a falling edge holds until the next rising
    // edge, so it tells whether that edge takes the item. Start stays high
    // when items follow back to back.
    task automatic issue(logic k, logic [15:0] req, logic [15:0] addr);
        if (idle_on && $urandom_range(99) < 15)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        start <= 1'b1;
        kind <= k;
        request_bytes <= req;
        block_address <= addr;
        while (busy)
            @(negedge clk);
        @(negedge clk);
    endtask

    // Directed items. Typed expectations cover the fresh heap, the field
    // extremes and the error codes; the other rows rely on the predictor.
    row_t directed [20] = '{
        '{KIND_ALLOC, 16'd1,     16'd0,     1, 16'd16, ilff_pkg::STATUS_OK},
        '{KIND_ALLOC, 16'd0,     16'd0,     1, 16'd0,  ilff_pkg::STATUS_ZERO},
        '{KIND_ALLOC, 16'hFFFF,  16'hFFFF,  1, 16'd0,  ilff_pkg::STATUS_FULL},
        '{KIND_ALLOC, 16'd8,     16'd0,     0, 16'd0,  ilff_pkg::STATUS_OK},
        '{KIND_ALLOC, 16'd100,   16'd0,     0, 16'd0,  ilff_pkg::STATUS_OK},
        '{KIND_ALLOC, 16'd40,    16'd0,     0, 16'd0,  ilff_pkg::STATUS_OK},
        '{KIND_FREE,  16'hFFFF,  16'd16,    1, 16'd0,  ilff_pkg::STATUS_OK},
        '{KIND_FREE,  16'd0,     16'd16,    1, 16'd0,  ilff_pkg::STATUS_OK},
        '{KIND_FREE,  16'd0,     16'd3,     1, 16'd0,  ilff_pkg::STATUS_OK},
        '{KIND_FREE,  16'd0,     16'hFFFF,  1, 16'd0,  ilff_pkg::STATUS_OK},
        '{KIND_FREE,  16'd0,     16'd0,     1, 16'd0,  ilff_pkg::STATUS_OK},
        '{KIND_ALLOC, 16'd5,     16'd0,     0, 16'd0,  ilff_pkg::STATUS_OK},
        '{KIND_FREE,  16'd0,     16'd48,    1, 16'd0,  ilff_pkg::STATUS_OK},
        '{KIND_FREE,  16'd0,     16'd32,    1, 16'd0,  ilff_pkg::STATUS_OK},
        '{KIND_ALLOC, 16'd64,    16'd0,     0, 16'd0,  ilff_pkg::STATUS_OK},
        '{KIND_ALLOC, 16'd30000, 16'd0,     0, 16'd0,  ilff_pkg::STATUS_OK},
        '{KIND_ALLOC, 16'd30000, 16'd0,     0, 16'd0,  ilff_pkg::STATUS_OK},
        '{KIND_ALLOC, 16'd30000, 16'd0,     1, 16'd0,  ilff_pkg::STATUS_FULL},
        '{KIND_ALLOC, 16'd4,     16'd0,     0, 16'd0,  ilff_pkg::STATUS_OK},
        '{KIND_ALLOC, 16'h5555,  16'hAAAA,  0, 16'd0,  ilff_pkg::STATUS_OK}
    };

    initial
    begin
        int          i, pick;
        logic [15:0] sz, ad;
        for (i = 0; i < TAG_WORDS; i++)
            heap_tag[i] = '0;
        heap_tag[1] = ilff_pkg::PROLOGUE_TAG;
        heap_tag[2] = ilff_pkg::PROLOGUE_TAG;
        heap_tag[3] = ilff_pkg::EPILOGUE_TAG;
        heap_end = 16;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[j])
        begin
            use_typed = directed[j].typed;
            typed_answer.addr = directed[j].exp_addr;
            typed_answer.stat = directed[j].exp_stat;
            issue(directed[j].k, directed[j].req, directed[j].addr);
        end
        use_typed = 1'b0;

        // Random traffic: mostly small blocks with frees of live blocks, so the
        // list keeps a few dozen blocks and the walks stay short, plus rare
        // large requests that run the heap out and stray free addresses.
        for (i = 0; i < 1280; i++)
        begin
            idle_on = !(i >= 400 && i < 700);
            pick = $urandom_range(99);
            if (live_blocks.size() > 48)
                pick = 70;
            if (pick < 55 || live_blocks.size() == 0)
            begin
                case ($urandom_range(99)) inside
                    [0:1]:   sz = 16'd0;
                    [2:3]:   sz = 16'($urandom_range(16'hFFFF, 16'h4000));
                    [4:10]:  sz = 16'($urandom_range(4096, 1));
                    default: sz = 16'($urandom_range(256, 1));
                endcase
                issue(KIND_ALLOC, sz, 16'($urandom));
            end
            else
            begin
                if ($urandom_range(9) < 8)
                    ad = live_blocks[$urandom_range(live_blocks.size() - 1)];
                else
                    ad = 16'($urandom);
                issue(KIND_FREE, 16'($urandom), ad);
            end
        end
        start <= 1'b0;

        while (pending_answers.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);

        $display("run: %0d allocations, %0d frees, %0d exhausted, %0d zero-size requests",
                 n_alloc, n_free, n_full, n_zero);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
